// ===== src/sorted_factor_list_merge_defines.svh =====
// Assertion macros used by the datapath RTL file of the factor list merge.
`ifndef SORTED_FACTOR_LIST_MERGE_DEFINES_SVH
`define SORTED_FACTOR_LIST_MERGE_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define SFLM_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("sflm: invariant violated");

// Condition in one cycle that forces a consequence in the next cycle.
`define SFLM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sflm: next-cycle check failed");

`endif

// ===== src/sflm_pkg.sv =====
`default_nettype none

package sflm_pkg;

   localparam int BASE_W         = 64;
   localparam int POWER_W        = 32;
   localparam int OP_W           = 2;
   localparam int LIST_DEPTH_DEF = 16;

   localparam logic [POWER_W-1:0] POWER_MAX = {POWER_W{1'b1}};

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_FIRST  = 2'd0,
      OP_LOAD_SECOND = 2'd1,
      OP_MERGE       = 2'd2
   } op_type;

   // controller -> datapath
   typedef struct packed {
      logic load_first;
      logic load_second;
      logic step;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;
      logic step_last;
   } status_type;

endpackage

`default_nettype wire

// ===== src/sflm_req_if.sv =====
`default_nettype none

interface sflm_req_if
   import sflm_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [BASE_W-1:0]  base_in;
   logic [POWER_W-1:0] power_in;

   modport source (output valid, output operation, output base_in, output power_in,
                   input ready);
   modport sink   (input valid, input operation, input base_in, input power_in,
                   output ready);
endinterface

`default_nettype wire

// ===== src/sflm_rsp_if.sv =====
`default_nettype none

interface sflm_rsp_if
   import sflm_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [BASE_W-1:0]  base_out;
   logic [POWER_W-1:0] power_out;
   logic               last_entry;
   logic               empty_result;
   logic               power_saturated;
   logic               load_overflow;

   modport source (output valid, output base_out, output power_out, output last_entry,
                   output empty_result, output power_saturated, output load_overflow,
                   input ready);
   modport sink   (input valid, input base_out, input power_out, input last_entry,
                   input empty_result, input power_saturated, input load_overflow,
                   output ready);
endinterface

`default_nettype wire

// ===== src/sorted_factor_list_merge.sv =====
// Load transfers return nothing; a new item is taken every cycle while no merge is running.
// A merge transfer enters the merge state, which then gives one result per cycle
// (stalls hold the output register), max(1, merged entry count) results in all.
// The next item is taken the cycle after the last result is registered.
// Reset is synchronous, active high: clears list counts, merge pointers, overflow flag,
// controller state and output valid; list storage is not cleared.
`default_nettype none

module sorted_factor_list_merge
   import sflm_pkg::*;
#(
   parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   sflm_req_if.sink   req_chan,
   sflm_rsp_if.source rsp_chan
);

   cmd_type    cmd;
   status_type status;

   sflm_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_operation (req_chan.operation),
      .req_ready     (req_chan.ready),
      .status        (status),
      .cmd           (cmd)
   );

   sflm_datapath #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .base_in         (req_chan.base_in),
      .power_in        (req_chan.power_in),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .base_out        (rsp_chan.base_out),
      .power_out       (rsp_chan.power_out),
      .last_entry      (rsp_chan.last_entry),
      .empty_result    (rsp_chan.empty_result),
      .power_saturated (rsp_chan.power_saturated),
      .load_overflow   (rsp_chan.load_overflow),
      .status          (status)
   );

endmodule

`default_nettype wire

// ===== src/sflm_ctrl.sv =====
`default_nettype none

module sflm_ctrl
   import sflm_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic [OP_W-1:0] req_operation,
   output logic                 req_ready,
   input  wire status_type      status,
   output cmd_type              cmd
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_MERGE = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      xfer;

   assign req_ready = (state_ff == ST_IDLE);
   assign xfer      = req_valid && req_ready;

   always_comb begin
      cmd.load_first  = xfer && (req_operation == OP_LOAD_FIRST);
      cmd.load_second = xfer && (req_operation == OP_LOAD_SECOND);
      cmd.step        = (state_ff == ST_MERGE) && status.out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (xfer && (req_operation == OP_MERGE)) state_in = ST_MERGE;
         end
         ST_MERGE: begin
            if (cmd.step && status.step_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

`default_nettype wire

// ===== src/sflm_datapath.sv =====
`default_nettype none

`include "sorted_factor_list_merge_defines.svh"

module sflm_datapath
   import sflm_pkg::*;
#(
   parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   input  wire logic [BASE_W-1:0]  base_in,
   input  wire logic [POWER_W-1:0] power_in,
   input  wire logic               rsp_ready,
   output logic                    rsp_valid,
   output logic [BASE_W-1:0]       base_out,
   output logic [POWER_W-1:0]      power_out,
   output logic                    last_entry,
   output logic                    empty_result,
   output logic                    power_saturated,
   output logic                    load_overflow,
   output status_type              status
);

   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

   // list storage, no reset: only entries below the count are read
   logic [BASE_W-1:0]  first_base_ff  [LIST_DEPTH];
   logic [POWER_W-1:0] first_power_ff [LIST_DEPTH];
   logic [BASE_W-1:0]  second_base_ff [LIST_DEPTH];
   logic [POWER_W-1:0] second_power_ff[LIST_DEPTH];

   logic [CW-1:0] first_count_ff, first_count_in;
   logic [CW-1:0] second_count_ff, second_count_in;
   logic [CW-1:0] fi_ff, fi_in;
   logic [CW-1:0] gi_ff, gi_in;
   logic          overflow_ff, overflow_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [BASE_W-1:0]  base_ff;
   logic [POWER_W-1:0] power_ff;
   logic               last_ff, empty_ff, sat_ff, ovf_ff;

   logic               first_full, second_full;
   logic               f_avail, g_avail;
   logic [BASE_W-1:0]  fb, gb;
   logic [POWER_W-1:0] fp, gp;
   logic [POWER_W:0]   psum;
   logic               take_f, take_g;
   logic [BASE_W-1:0]  sel_base;
   logic [POWER_W-1:0] sel_power;
   logic               sel_sat, sel_empty;
   logic [CW-1:0]      fi_next, gi_next;
   logic               step_last;

   assign first_full  = (first_count_ff >= DEPTH_C);
   assign second_full = (second_count_ff >= DEPTH_C);

   assign f_avail = (fi_ff < first_count_ff);
   assign g_avail = (gi_ff < second_count_ff);
   assign fb      = first_base_ff[fi_ff[IW-1:0]];
   assign fp      = first_power_ff[fi_ff[IW-1:0]];
   assign gb      = second_base_ff[gi_ff[IW-1:0]];
   assign gp      = second_power_ff[gi_ff[IW-1:0]];
   assign psum    = {1'b0, fp} + {1'b0, gp};

   // one merge step: equal bases combine, else the smaller base goes first
   always_comb begin
      take_f    = 1'b0;
      take_g    = 1'b0;
      sel_base  = '0;
      sel_power = '0;
      sel_sat   = 1'b0;
      sel_empty = 1'b0;
      priority if (f_avail && g_avail && (fb == gb)) begin
         take_f    = 1'b1;
         take_g    = 1'b1;
         sel_base  = fb;
         sel_sat   = psum[POWER_W];
         sel_power = psum[POWER_W] ? POWER_MAX : psum[POWER_W-1:0];
      end else if (f_avail && (!g_avail || (fb < gb))) begin
         take_f    = 1'b1;
         sel_base  = fb;
         sel_power = fp;
      end else if (g_avail) begin
         take_g    = 1'b1;
         sel_base  = gb;
         sel_power = gp;
      end else begin
         // both lists empty at merge start
         sel_empty = 1'b1;
      end
   end

   assign fi_next   = fi_ff + CW'(take_f);
   assign gi_next   = gi_ff + CW'(take_g);
   assign step_last = (fi_next == first_count_ff) && (gi_next == second_count_ff);

   always_comb begin
      status.out_free  = !rsp_valid_ff || rsp_ready;
      status.step_last = step_last;
   end

   always_comb begin
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      fi_in           = fi_ff;
      gi_in           = gi_ff;
      overflow_in     = overflow_ff;
      if (cmd.load_first) begin
         if (first_full) overflow_in = 1'b1;
         else            first_count_in = first_count_ff + CW'(1);
      end
      if (cmd.load_second) begin
         if (second_full) overflow_in = 1'b1;
         else             second_count_in = second_count_ff + CW'(1);
      end
      if (cmd.step) begin
         if (step_last) begin
            first_count_in  = '0;
            second_count_in = '0;
            fi_in           = '0;
            gi_in           = '0;
            overflow_in     = 1'b0;
         end else begin
            fi_in = fi_next;
            gi_in = gi_next;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.step)      rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_count_ff  <= '0;
         second_count_ff <= '0;
         fi_ff           <= '0;
         gi_ff           <= '0;
         overflow_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         fi_ff           <= fi_in;
         gi_ff           <= gi_in;
         overflow_ff     <= overflow_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_first && !first_full) begin
         first_base_ff[first_count_ff[IW-1:0]]  <= base_in;
         first_power_ff[first_count_ff[IW-1:0]] <= power_in;
      end
      if (cmd.load_second && !second_full) begin
         second_base_ff[second_count_ff[IW-1:0]]  <= base_in;
         second_power_ff[second_count_ff[IW-1:0]] <= power_in;
      end
      if (cmd.step) begin
         base_ff  <= sel_base;
         power_ff <= sel_power;
         last_ff  <= step_last;
         empty_ff <= sel_empty;
         sat_ff   <= sel_sat;
         ovf_ff   <= overflow_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign base_out        = base_ff;
   assign power_out       = power_ff;
   assign last_entry      = last_ff;
   assign empty_result    = empty_ff;
   assign power_saturated = sat_ff;
   assign load_overflow   = ovf_ff;

   `SFLM_ASSERT_ALWAYS(a_ptr_in_range, clock, reset,
      (fi_ff <= first_count_ff) && (gi_ff <= second_count_ff))
   `SFLM_ASSERT_ALWAYS(a_count_in_range, clock, reset,
      (first_count_ff <= DEPTH_C) && (second_count_ff <= DEPTH_C))
   `SFLM_ASSERT_NEXT(a_clear_after_last, clock, reset, cmd.step && step_last,
      (first_count_ff == '0) && (second_count_ff == '0) && !overflow_ff && last_entry)
   `SFLM_ASSERT_NEXT(a_no_step_while_stalled, clock, reset, rsp_valid_ff && !rsp_ready,
      rsp_valid_ff)

endmodule

`default_nettype wire
